>>> rtl/hcsm_pkg.sv
package hcsm_pkg;

    localparam int ROUNDS_DEFAULT = 3;

    localparam int TIME_W  = 16;
    localparam int DIV_W   = 26;
    localparam int DIVR_W  = 16;

    localparam logic [15:0]      WINDOW_RESET  = 16'd50000;
    localparam logic [15:0]      NO_DATA       = 16'd22222;
    localparam logic [15:0]      SPEED_MAX     = 16'hFFFF;
    localparam logic [DIV_W-1:0] US_PER_MINUTE = 26'd60000000;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> rtl/hcsm_divider.sv
// Restoring divider, one quotient bit per cycle.
module hcsm_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  hcsm_pkg::div_req_t req,
    output hcsm_pkg::div_rsp_t rsp
);

    localparam int DW = hcsm_pkg::DIV_W;
    localparam int VW = hcsm_pkg::DIVR_W;
    localparam int CW = $clog2(DW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] dvs_reg, dvs_next;

    logic [VW:0]   shifted;
    logic [VW:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, quo_reg[DW-1]};
        diff      = shifted - {1'b0, dvs_reg};

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[VW])
            begin
                rem_next = diff[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> rtl/hcsm_slot_file.sv
// Capture slot registers: one write port, one read port.
module hcsm_slot_file
#(
    parameter int SLOTS = 3 * hcsm_pkg::ROUNDS_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(SLOTS)-1:0]   wr_addr,
    input  logic [hcsm_pkg::TIME_W-1:0] wr_data,
    input  logic [$clog2(SLOTS)-1:0]   rd_addr,
    output logic [hcsm_pkg::TIME_W-1:0] rd_data
);

    logic [hcsm_pkg::TIME_W-1:0] slot_reg [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = slot_reg[rd_addr];

endmodule

>>> rtl/hall_capture_speed_meter_top.sv
// Hall capture speed meter, counter-clockwise path.
// Input channel (in_valid/in_ready): one request per microsecond tick, carrying
// rising-edge flags edge_a/b/c and ccw_active. Output channel (out_valid/
// out_ready): one result at the end of each measurement window, with period,
// rpm, completed rounds and the no-capture / zero-period flags.
// cfg_wr_en/cfg_wr_data write window_ticks at any edge; write only when idle.
// A tick that ends no window goes through the accept step and then the A, B and C
// edge steps, which share the single slot write port. A window end adds, when
// any round was seen, the sum of the 3n slots (n = rounds) and a pass through
// the restoring divider for the period; a second pass for the rpm follows
// unless the period is zero. in_ready is low while a tick is in work.
// A finished result sits in the output register; the next tick is accepted
// while it waits. If a second window ends before out_ready takes the first,
// the block holds that result and keeps in_ready low until it is taken.
// Reset: window_ticks = 50000, timer, window count, rounds and flags cleared;
// capture stays off until the first window end.
module hall_capture_speed_meter_top
#(
    parameter int ROUNDS = hcsm_pkg::ROUNDS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        edge_a,
    input  logic        edge_b,
    input  logic        edge_c,
    input  logic        ccw_active,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] period_us,
    output logic [15:0] speed_rpm,
    output logic [1:0]  rounds_seen,
    output logic        no_capture,
    output logic        zero_period,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam int SLOTS = 3 * ROUNDS;
    localparam int AW    = $clog2(SLOTS);
    localparam int PW    = $clog2(SLOTS + 1);
    localparam int TW    = hcsm_pkg::TIME_W;
    localparam int DW    = hcsm_pkg::DIV_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EA,
        S_EB,
        S_EC,
        S_SUM,
        S_P_START,
        S_P_WAIT,
        S_R_START,
        S_R_WAIT,
        S_OUT
    } state_t;

    state_t         state_reg, state_next;
    logic [15:0]    window_ticks_reg, window_ticks_next;
    logic [TW-1:0]  timer_reg, timer_next;
    logic [15:0]    window_count_reg, window_count_next;
    logic           en_reg, en_next;
    logic           armed_reg, armed_next;
    logic           bflag_reg, bflag_next;
    logic           cflag_reg, cflag_next;
    logic [1:0]     round_reg, round_next;
    logic [PW-1:0]  ptr_reg, ptr_next;
    logic           restart_reg, restart_next;
    logic           ea_reg, ea_next;
    logic           eb_reg, eb_next;
    logic           ec_reg, ec_next;
    logic           ccw_reg, ccw_next;
    logic [1:0]     n_reg, n_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [TW-1:0]  acc_reg, acc_next;
    logic [15:0]    res_period_reg, res_period_next;
    logic [15:0]    res_speed_reg, res_speed_next;
    logic           res_none_reg, res_none_next;
    logic           res_zero_reg, res_zero_next;
    logic           out_valid_reg, out_valid_next;
    logic [15:0]    period_reg, period_next;
    logic [15:0]    speed_reg, speed_next;
    logic [1:0]     rounds_reg, rounds_next;
    logic           none_reg, none_next;
    logic           zero_reg, zero_next;

    logic           slot_we;
    logic [TW-1:0]  slot_rdata;
    logic           store;
    logic [AW-1:0]  sum_last;
    logic [16:0]    count_inc;
    logic           ccw_en;

    hcsm_pkg::div_req_t div_req;
    hcsm_pkg::div_rsp_t div_rsp;

    hcsm_slot_file #(
        .SLOTS (SLOTS)
    ) u_slots (
        .clk     (clk),
        .wr_en   (slot_we),
        .wr_addr (ptr_reg[AW-1:0]),
        .wr_data (timer_reg),
        .rd_addr (idx_reg),
        .rd_data (slot_rdata)
    );

    hcsm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign ccw_en   = ccw_reg && en_reg;
    assign sum_last = AW'((PW'(n_reg) << 1) + PW'(n_reg) - PW'(1));
    assign count_inc = {1'b0, window_count_reg} + 17'd1;

    always_comb
    begin
        state_next        = state_reg;
        window_ticks_next = cfg_wr_en ? cfg_wr_data : window_ticks_reg;
        timer_next        = timer_reg;
        window_count_next = window_count_reg;
        en_next           = en_reg;
        armed_next        = armed_reg;
        bflag_next        = bflag_reg;
        cflag_next        = cflag_reg;
        round_next        = round_reg;
        ptr_next          = ptr_reg;
        restart_next      = restart_reg;
        ea_next           = ea_reg;
        eb_next           = eb_reg;
        ec_next           = ec_reg;
        ccw_next          = ccw_reg;
        n_next            = n_reg;
        idx_next          = idx_reg;
        acc_next          = acc_reg;
        res_period_next   = res_period_reg;
        res_speed_next    = res_speed_reg;
        res_none_next     = res_none_reg;
        res_zero_next     = res_zero_reg;
        period_next       = period_reg;
        speed_next        = speed_reg;
        rounds_next       = rounds_reg;
        none_next         = none_reg;
        zero_next         = zero_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        store             = 1'b0;
        div_req.start     = 1'b0;
        div_req.dividend  = {{(DW - TW){1'b0}}, acc_reg};
        div_req.divisor   = {13'd0, n_reg, 1'b0};

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ea_next      = edge_a;
                    eb_next      = edge_b;
                    ec_next      = edge_c;
                    ccw_next     = ccw_active;
                    restart_next = 1'b0;
                    state_next   = S_EA;
                end
            end

            S_EA:
            begin
                if (ccw_en && ea_reg)
                begin
                    if (cflag_reg)
                    begin
                        store      = 1'b1;
                        round_next = round_reg + 2'd1;
                        armed_next = 1'b0;
                        bflag_next = 1'b0;
                        cflag_next = 1'b0;
                        en_next    = !((32'(round_reg) + 1) >= ROUNDS);
                    end
                    else
                    begin
                        restart_next = 1'b1;
                        armed_next   = 1'b1;
                    end
                end
                state_next = S_EB;
            end

            S_EB:
            begin
                if (ccw_en && eb_reg && armed_reg)
                begin
                    store      = 1'b1;
                    bflag_next = 1'b1;
                end
                state_next = S_EC;
            end

            S_EC:
            begin
                if (ccw_en && ec_reg && bflag_reg)
                begin
                    store      = 1'b1;
                    cflag_next = 1'b1;
                end
                timer_next = restart_reg ? TW'(1) : timer_reg + TW'(1);
                if (count_inc < {1'b0, window_ticks_reg})
                begin
                    window_count_next = count_inc[15:0];
                    state_next        = S_IDLE;
                end
                else
                begin
                    // window end: rearm and start the average, or report no capture
                    window_count_next = '0;
                    n_next            = round_reg;
                    round_next        = '0;
                    ptr_next          = '0;
                    en_next           = 1'b1;
                    armed_next        = 1'b0;
                    bflag_next        = 1'b0;
                    cflag_next        = 1'b0;
                    idx_next          = '0;
                    acc_next          = '0;
                    res_none_next     = 1'b0;
                    res_zero_next     = 1'b0;
                    // a C capture in the closing tick is not stored
                    store             = 1'b0;
                    if (round_reg == 2'd0)
                    begin
                        res_period_next = hcsm_pkg::NO_DATA;
                        res_speed_next  = hcsm_pkg::NO_DATA;
                        res_none_next   = 1'b1;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SUM;
                    end
                end
            end

            S_SUM:
            begin
                acc_next = acc_reg + slot_rdata;
                idx_next = idx_reg + AW'(1);
                if (idx_reg == sum_last)
                begin
                    state_next = S_P_START;
                end
            end

            S_P_START:
            begin
                div_req.start = 1'b1;
                state_next    = S_P_WAIT;
            end

            S_P_WAIT:
            begin
                if (div_rsp.done)
                begin
                    res_period_next = div_rsp.quotient[15:0];
                    if (div_rsp.quotient == '0)
                    begin
                        res_zero_next  = 1'b1;
                        res_speed_next = hcsm_pkg::SPEED_MAX;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        state_next = S_R_START;
                    end
                end
            end

            S_R_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = hcsm_pkg::US_PER_MINUTE;
                div_req.divisor  = res_period_reg;
                state_next       = S_R_WAIT;
            end

            S_R_WAIT:
            begin
                if (div_rsp.done)
                begin
                    res_speed_next = (|div_rsp.quotient[DW-1:16]) ? hcsm_pkg::SPEED_MAX
                                                                   : div_rsp.quotient[15:0];
                    state_next     = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    period_next    = res_period_reg;
                    speed_next     = res_speed_reg;
                    rounds_next    = n_reg;
                    none_next      = res_none_reg;
                    zero_next      = res_zero_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // store drops once every slot is used
        slot_we = store && (ptr_reg < PW'(SLOTS));
        if (slot_we)
        begin
            ptr_next = ptr_reg + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            window_ticks_reg <= hcsm_pkg::WINDOW_RESET;
            timer_reg        <= '0;
            window_count_reg <= '0;
            en_reg           <= 1'b0;
            armed_reg        <= 1'b0;
            bflag_reg        <= 1'b0;
            cflag_reg        <= 1'b0;
            round_reg        <= '0;
            ptr_reg          <= '0;
            restart_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            window_ticks_reg <= window_ticks_next;
            timer_reg        <= timer_next;
            window_count_reg <= window_count_next;
            en_reg           <= en_next;
            armed_reg        <= armed_next;
            bflag_reg        <= bflag_next;
            cflag_reg        <= cflag_next;
            round_reg        <= round_next;
            ptr_reg          <= ptr_next;
            restart_reg      <= restart_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ea_reg         <= ea_next;
        eb_reg         <= eb_next;
        ec_reg         <= ec_next;
        ccw_reg        <= ccw_next;
        n_reg          <= n_next;
        idx_reg        <= idx_next;
        acc_reg        <= acc_next;
        res_period_reg <= res_period_next;
        res_speed_reg  <= res_speed_next;
        res_none_reg   <= res_none_next;
        res_zero_reg   <= res_zero_next;
        period_reg     <= period_next;
        speed_reg      <= speed_next;
        rounds_reg     <= rounds_next;
        none_reg       <= none_next;
        zero_reg       <= zero_next;
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign period_us   = period_reg;
    assign speed_rpm   = speed_reg;
    assign rounds_seen = rounds_reg;
    assign no_capture  = none_reg;
    assign zero_period = zero_reg;

endmodule

>>> verif/tb_hall_capture_speed_meter_top.sv
module tb_hall_capture_speed_meter_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT     = 9;
    localparam int ROUNDS         = hcsm_pkg::ROUNDS_DEFAULT;
    localparam int SETTLE_CYCLES  = 150;
    localparam int HOLD_CYCLES    = 1200;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int MAX_SHOWN      = 10;

    // phase flag bits of the capture sequencer
    localparam int FLAG_EN    = 0;
    localparam int FLAG_ARMED = 1;
    localparam int FLAG_B     = 2;
    localparam int FLAG_C     = 3;

    typedef struct packed {
        logic edge_a;
        logic edge_b;
        logic edge_c;
        logic ccw_active;
    } hall_tick_t;

    typedef struct packed {
        logic [15:0] period_us;
        logic [15:0] speed_rpm;
        logic [1:0]  rounds_seen;
        logic        no_capture;
        logic        zero_period;
    } speed_report_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        edge_a      = 1'b0;
    logic        edge_b      = 1'b0;
    logic        edge_c      = 1'b0;
    logic        ccw_active  = 1'b0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [15:0] period_us;
    logic [15:0] speed_rpm;
    logic [1:0]  rounds_seen;
    logic        no_capture;
    logic        zero_period;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;

    // speed meter state as the block should hold it
    logic [15:0] meter_window       = hcsm_pkg::WINDOW_RESET;
    logic [15:0] meter_timer        = '0;
    logic [15:0] meter_window_count = '0;
    logic [3:0]  meter_flags        = '0;
    logic [1:0]  meter_rounds       = '0;
    int          meter_slot_ptr     = 0;
    logic [15:0] meter_slots [SLOT_COUNT] = '{default: '0};

    hall_tick_t    hall_ticks_to_send [$];
    speed_report_t expected_reports [$];
    hall_tick_t    cur_tick;
    speed_report_t predicted;
    speed_report_t got;
    speed_report_t want;

    int send_idle_pct  = 6;
    int recv_idle_pct  = 67;
    int hold_requests  = 0;
    int hold_grants    = 0;
    int hold_left      = 0;
    int mismatch_count = 0;
    int stall_cycles   = 0;

    hall_capture_speed_meter_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .edge_a      (edge_a),
        .edge_b      (edge_b),
        .edge_c      (edge_c),
        .ccw_active  (ccw_active),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .period_us   (period_us),
        .speed_rpm   (speed_rpm),
        .rounds_seen (rounds_seen),
        .no_capture  (no_capture),
        .zero_period (zero_period),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #2 clk = ~clk;

    function automatic void latch_capture(input logic [15:0] value);
        if (meter_slot_ptr < SLOT_COUNT)
        begin
            meter_slots[meter_slot_ptr] = value;
            meter_slot_ptr++;
        end
    endfunction

    // Advances the meter by one tick; returns 1 when the tick closes a window.
    function automatic bit meter_tick(input hall_tick_t t, output speed_report_t r);
        logic [15:0] now;
        logic [15:0] sum;
        logic [16:0] next_count;
        int unsigned n;
        int unsigned period;
        int unsigned rpm;
        int          i;
        bit          restart;
        now = meter_timer;
        restart = 1'b0;
        r = '0;
        if (t.ccw_active && meter_flags[FLAG_EN])
        begin
            if (t.edge_a)
            begin
                if (meter_flags[FLAG_C])
                begin
                    latch_capture(now);
                    meter_rounds = meter_rounds + 2'd1;
                    meter_flags = '0;
                    meter_flags[FLAG_EN] = (meter_rounds < ROUNDS);
                end
                else
                begin
                    restart = 1'b1;
                    meter_flags[FLAG_ARMED] = 1'b1;
                end
            end
            if (t.edge_b && meter_flags[FLAG_EN] && meter_flags[FLAG_ARMED])
            begin
                latch_capture(now);
                meter_flags[FLAG_B] = 1'b1;
            end
            if (t.edge_c && meter_flags[FLAG_EN] && meter_flags[FLAG_B])
            begin
                latch_capture(now);
                meter_flags[FLAG_C] = 1'b1;
            end
        end
        // edges in the arming tick still see the old timer value
        meter_timer = restart ? 16'd1 : now + 16'd1;

        next_count = {1'b0, meter_window_count} + 17'd1;
        if (next_count < {1'b0, meter_window})
        begin
            meter_window_count = next_count[15:0];
            return 1'b0;
        end
        meter_window_count = '0;

        n = meter_rounds;
        r.rounds_seen = meter_rounds;
        if (n == 0)
        begin
            r.period_us  = hcsm_pkg::NO_DATA;
            r.speed_rpm  = hcsm_pkg::NO_DATA;
            r.no_capture = 1'b1;
        end
        else
        begin
            sum = '0;
            for (i = 0; i < 3 * n; i++)
                sum = sum + meter_slots[i];
            period = sum / (2 * n);
            r.period_us = period[15:0];
            if (period == 0)
            begin
                r.zero_period = 1'b1;
                r.speed_rpm   = hcsm_pkg::SPEED_MAX;
            end
            else
            begin
                rpm = hcsm_pkg::US_PER_MINUTE / period;
                r.speed_rpm = (rpm > 32'hFFFF) ? hcsm_pkg::SPEED_MAX : rpm[15:0];
            end
        end

        meter_slots    = '{default: '0};
        meter_rounds   = '0;
        meter_slot_ptr = 0;
        meter_flags    = '0;
        meter_flags[FLAG_EN] = 1'b1;
        return 1'b1;
    endfunction

    // driver: one request per tick, expectation formed when the request is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (meter_tick(cur_tick, predicted))
                    expected_reports.push_back(predicted);
            end
            if (!in_valid || in_ready)
            begin
                if (hall_ticks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_tick = hall_ticks_to_send.pop_front();
                    in_valid   <= 1'b1;
                    edge_a     <= cur_tick.edge_a;
                    edge_b     <= cur_tick.edge_b;
                    edge_c     <= cur_tick.edge_c;
                    ccw_active <= cur_tick.ccw_active;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {period_us, speed_rpm, rounds_seen, no_capture, zero_period};
                if (expected_reports.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display("unexpected speed report: period %0d rpm %0d rounds %0d %b%b",
                                 got.period_us, got.speed_rpm, got.rounds_seen,
                                 got.no_capture, got.zero_period);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_SHOWN)
                            $display({"speed report mismatch: exp period %0d rpm %0d rounds %0d",
                                      " none %b zero %b / got period %0d rpm %0d rounds %0d",
                                      " none %b zero %b"},
                                     want.period_us, want.speed_rpm, want.rounds_seen,
                                     want.no_capture, want.zero_period,
                                     got.period_us, got.speed_rpm, got.rounds_seen,
                                     got.no_capture, got.zero_period);
                    end
                end
            end

            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_grants != hold_requests)
            begin
                hold_grants = hold_requests;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb_hall_capture_speed_meter_top: FAIL");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic void queue_tick(input bit a, input bit b, input bit c, input bit ccw);
        hall_ticks_to_send.push_back(hall_tick_t'({a, b, c, ccw}));
    endfunction

    // ticks with the direction inactive: edges must be ignored
    function automatic void queue_ignored(input int count);
        hall_tick_t t;
        repeat (count)
        begin
            t = hall_tick_t'(4'($urandom));
            t.ccw_active = 1'b0;
            hall_ticks_to_send.push_back(t);
        end
    endfunction

    // mostly well-formed A-B-C-A rounds with short gaps, the rest noise
    function automatic void queue_rounds(input int count);
        hall_tick_t t;
        int left;
        int stage;
        int gap;
        left = count;
        while (left > 0)
        begin
            if ($urandom_range(99) < 80)
            begin
                for (stage = 0; stage < 4; stage++)
                begin
                    gap = $urandom_range(5, 0);
                    repeat (gap)
                    begin
                        t = '0;
                        t.ccw_active = 1'b1;
                        if ($urandom_range(99) < 8)
                            t = hall_tick_t'(4'($urandom));
                        hall_ticks_to_send.push_back(t);
                        left--;
                    end
                    t = '0;
                    t.ccw_active = 1'b1;
                    case (stage)
                        1:       t.edge_b = 1'b1;
                        2:       t.edge_c = 1'b1;
                        default: t.edge_a = 1'b1;
                    endcase
                    if ($urandom_range(99) < 15)
                        t = t | hall_tick_t'(4'($urandom));
                    hall_ticks_to_send.push_back(t);
                    left--;
                end
            end
            else
            begin
                repeat ($urandom_range(8, 1))
                begin
                    hall_ticks_to_send.push_back(hall_tick_t'(4'($urandom)));
                    left--;
                end
            end
        end
    endfunction

    // waits until every request is taken and every report is in, then lets the block settle
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (hall_ticks_to_send.size() != 0 || in_valid || expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [15:0] ticks);
        wait_quiet();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        meter_window = ticks;
    endtask

    initial
    begin
        int          g1;
        int          g2;
        int          g3;
        int          phase;
        int          roll;
        logic [15:0] win;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // capture is off until the first window closes
        queue_tick(1, 1, 1, 1);
        queue_tick(0, 1, 1, 1);
        queue_tick(1, 0, 1, 1);
        queue_tick(0, 0, 0, 1);

        // zero window behaves as one tick: every tick reports, nothing captured
        write_window(16'd0);
        queue_tick(0, 0, 0, 1);
        queue_tick(1, 1, 1, 1);
        queue_tick(0, 1, 1, 0);

        write_window(16'd20);
        queue_tick(1, 0, 0, 1);   // arm
        queue_tick(0, 0, 1, 1);   // C before B is ignored
        queue_tick(0, 1, 0, 1);
        queue_tick(0, 1, 0, 1);   // repeated B stores again
        queue_tick(0, 0, 1, 1);
        queue_tick(1, 0, 0, 1);   // round 1 done
        queue_tick(0, 1, 0, 1);   // not armed
        queue_tick(1, 1, 1, 1);   // arm, B and C latch the pre-restart timer
        queue_tick(1, 1, 1, 0);   // direction inactive
        queue_tick(1, 0, 0, 1);   // round 2 done
        queue_tick(1, 0, 0, 1);
        queue_tick(0, 1, 1, 1);   // slots now full
        queue_tick(1, 0, 0, 1);   // round 3, store dropped, capture stops
        queue_tick(1, 1, 1, 1);
        queue_ignored(6);

        write_window(16'hFFFF);
        queue_rounds(40);

        // close the long window so the next one starts aligned
        write_window(16'd1);
        queue_tick(0, 0, 0, 1);

        // slow rotation so the rpm is not saturated
        write_window(16'd760);
        g1 = $urandom_range(700, 620);
        g2 = $urandom_range(20, 1);
        g3 = $urandom_range(20, 1);
        queue_tick(1, 0, 0, 1);
        queue_ignored(g1 - 1);
        queue_tick(0, 1, 0, 1);
        queue_ignored(g2 - 1);
        queue_tick(0, 0, 1, 1);
        queue_ignored(g3 - 1);
        queue_tick(1, 0, 0, 1);
        queue_ignored(760 - 1 - g1 - g2 - g3);

        for (phase = 0; phase < 6; phase++)
        begin
            roll = $urandom_range(99);
            if (roll < 25)
                win = 16'($urandom_range(4, 1));
            else if (roll < 75)
                win = 16'($urandom_range(40, 5));
            else
                win = 16'($urandom_range(300, 41));
            if (phase == 4)
                win = 16'd2;
            write_window(win);
            if (phase == 2)
            begin
                send_idle_pct = 67;
                recv_idle_pct = 6;
            end
            else if (phase == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            queue_rounds(100);
            // long receiver hold-off with a two-tick window: results pile up, input stalls
            if (phase == 4)
                hold_requests++;
        end

        wait_quiet();
        if (mismatch_count == 0)
            $display("tb_hall_capture_speed_meter_top: PASS");
        else
            $display("tb_hall_capture_speed_meter_top: FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/hcsm_pkg.sv
rtl/hcsm_divider.sv
rtl/hcsm_slot_file.sv
rtl/hall_capture_speed_meter_top.sv
verif/tb_hall_capture_speed_meter_top.sv
